### rtl/core/mkrt_pkg.sv
// shared types and constants for the min-key record table
// record layout, table sizing, and the controller/datapath command and status groups
// no dependencies
package mkrt_pkg;

    localparam int DEPTH    = 32;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    localparam int KEY_W    = 16;
    localparam int ID_W     = 24;
    localparam int HANDLE_W = 32;
    localparam int OCC_W    = 6;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 80;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [ID_W-1:0]     id;
        logic [KEY_W-1:0]    key;
    } rec_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;      // capture the accepted item
        logic scan_start;   // read pointer to slot 0
        logic shift_start;  // read pointer to the slot after the pick
        logic rd_en;        // read the slot at the pointer, advance pointer
        logic rd_shift;     // that read feeds the compaction rather than the scan
        logic finish;       // commit the item and load the result register
    } mkrt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_remove;
        logic count_zero;
        logic ptr_last;
        logic shift_none;
        logic out_free;
    } mkrt_sts_t;

endpackage

### rtl/core/min_key_record_table_top.sv
// min-key record table, top level: controller, datapath and stream ports
// an insert or a failed remove goes from accept through decode to commit; a remove of n held
//   records scans all n slots, then compacts the records after the picked slot one place down
// one item at a time, the input closed from accept until commit; scan and compaction share
//   the one memory read port, and a held result delays commit
// reset (rst_n, async active low) empties the table; the record memory is not cleared
module min_key_record_table_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [mkrt_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // record_id[23:0], record_key[39:24],
                                                            // name_handle[71:40]
    input  logic        s_axis_tuser,   // action: 0 insert, 1 remove minimum

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [mkrt_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // removed_key[15:0], removed_id[39:16],
                                                            // removed_name[71:40], occupancy[77:72],
                                                            // zero[79:78]
    output logic        m_axis_tuser    // done_ok
);

    mkrt_pkg::mkrt_cmd_t cmd;
    mkrt_pkg::mkrt_sts_t sts;

    mkrt_pkg::rec_t               in_rec;
    mkrt_pkg::rec_t               out_rec;
    logic                         out_ok;
    logic [mkrt_pkg::OCC_W-1:0]   out_occ;

    // unpack the incoming item
    assign in_rec.id     = s_axis_tdata[23:0];
    assign in_rec.key    = s_axis_tdata[39:24];
    assign in_rec.handle = s_axis_tdata[71:40];

    // state machine: accept, scan, compaction, commit
    mkrt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // memory, count, compare and result register
    mkrt_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_action (s_axis_tuser),
        .in_rec    (in_rec),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ok    (out_ok),
        .out_rec   (out_rec),
        .out_occ   (out_occ)
    );

    // pack the result item
    assign m_axis_tdata = {2'b00, out_occ, out_rec.handle, out_rec.id, out_rec.key};
    assign m_axis_tuser = out_ok;

    // an accepted item keeps the input closed for the following cycle
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready
    ) else $error("input ready right after an accept");

    // a result only appears from a commit
    a_result_from_commit: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.finish)
    ) else $error("result valid without a commit");

    // memory reads never overlap accepting a new item
    a_no_read_while_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> !s_axis_tready
    ) else $error("memory read while input open");

endmodule

### rtl/core/mkrt_ctrl.sv
// controller state machine for the min-key record table
// sequences scan, compaction and commit through command signals
// depends on mkrt_pkg
module mkrt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mkrt_pkg::mkrt_sts_t sts,
    output mkrt_pkg::mkrt_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SCAN_WAIT,
        S_SHIFT_SETUP,
        S_SHIFT,
        S_SHIFT_WAIT,
        S_FINISH
    } state_t;

    state_t st_reg;
    state_t st_next;

    always_comb
    begin
        st_next  = st_reg;
        cmd      = '0;
        in_ready = 1'b0;
        case (st_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    st_next     = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_remove && !sts.count_zero)
                begin
                    cmd.scan_start = 1'b1;
                    st_next        = S_SCAN;
                end
                else
                begin
                    st_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (sts.ptr_last)
                begin
                    st_next = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT:
            begin
                st_next = S_SHIFT_SETUP;
            end
            S_SHIFT_SETUP:
            begin
                if (sts.shift_none)
                begin
                    st_next = S_FINISH;
                end
                else
                begin
                    cmd.shift_start = 1'b1;
                    st_next         = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_shift = 1'b1;
                if (sts.ptr_last)
                begin
                    st_next = S_SHIFT_WAIT;
                end
            end
            S_SHIFT_WAIT:
            begin
                st_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    st_next    = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

### rtl/core/mkrt_dp.sv
// datapath for the min-key record table: record memory, count, scan compare,
// compaction path and result register
// depends on mkrt_pkg
module mkrt_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  mkrt_pkg::mkrt_cmd_t               cmd,
    output mkrt_pkg::mkrt_sts_t               sts,
    input  logic                              in_action,
    input  mkrt_pkg::rec_t                    in_rec,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic                              out_ok,
    output mkrt_pkg::rec_t                    out_rec,
    output logic [mkrt_pkg::OCC_W-1:0]        out_occ
);

    mkrt_pkg::rec_t rec_mem [mkrt_pkg::DEPTH];

    logic                        act_reg;
    mkrt_pkg::rec_t              in_reg;
    logic [mkrt_pkg::CNT_W-1:0]  count_reg;
    logic [mkrt_pkg::CNT_W-1:0]  count_next;
    logic [mkrt_pkg::ADDR_W-1:0] ptr_reg;
    logic [mkrt_pkg::ADDR_W-1:0] ptr_next;

    mkrt_pkg::rec_t              rd_data_reg;
    logic                        rd_vld_reg;
    logic                        rd_shift_reg;
    logic [mkrt_pkg::ADDR_W-1:0] rd_idx_reg;

    mkrt_pkg::rec_t              best_reg;
    logic [mkrt_pkg::ADDR_W-1:0] pick_reg;

    logic                        out_vld_reg;
    logic                        out_vld_next;
    logic                        out_ok_reg;
    mkrt_pkg::rec_t              out_rec_reg;
    logic [mkrt_pkg::OCC_W-1:0]  out_occ_reg;

    logic                        take;
    logic                        can_insert;
    logic                        can_remove;
    logic                        mem_we;
    logic [mkrt_pkg::ADDR_W-1:0] mem_waddr;
    mkrt_pkg::rec_t              mem_wdata;

    assign can_insert = (act_reg == mkrt_pkg::ACT_INSERT)
                        && (count_reg < mkrt_pkg::CNT_W'(mkrt_pkg::DEPTH));
    assign can_remove = (act_reg == mkrt_pkg::ACT_REMOVE) && (count_reg != '0);

    // scan keeps the later slot on equal keys, so the newest minimum wins
    assign take = rd_vld_reg && !rd_shift_reg
                  && ((rd_idx_reg == '0) || (rd_data_reg.key <= best_reg.key));

    assign sts.is_remove  = (act_reg == mkrt_pkg::ACT_REMOVE);
    assign sts.count_zero = (count_reg == '0);
    assign sts.ptr_last   = (mkrt_pkg::CNT_W'(ptr_reg) == (count_reg - mkrt_pkg::CNT_W'(1)));
    assign sts.shift_none = ((mkrt_pkg::CNT_W'(pick_reg) + mkrt_pkg::CNT_W'(1)) == count_reg);
    assign sts.out_free   = !out_vld_reg || out_ready;

    // compaction writes each read slot one place down; commit of an insert writes the new newest slot
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = rd_idx_reg - mkrt_pkg::ADDR_W'(1);
        mem_wdata = rd_data_reg;
        if (rd_vld_reg && rd_shift_reg)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.finish && can_insert)
        begin
            mem_we    = 1'b1;
            mem_waddr = count_reg[mkrt_pkg::ADDR_W-1:0];
            mem_wdata = in_reg;
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.scan_start)
        begin
            ptr_next = '0;
        end
        else if (cmd.shift_start)
        begin
            ptr_next = pick_reg + mkrt_pkg::ADDR_W'(1);
        end
        else if (cmd.rd_en)
        begin
            ptr_next = ptr_reg + mkrt_pkg::ADDR_W'(1);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.finish && can_insert)
        begin
            count_next = count_reg + mkrt_pkg::CNT_W'(1);
        end
        else if (cmd.finish && can_remove)
        begin
            count_next = count_reg - mkrt_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (cmd.finish)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // record memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rec_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= rec_mem[ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ptr_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            rd_shift_reg <= 1'b0;
            rd_idx_reg   <= '0;
            act_reg      <= mkrt_pkg::ACT_INSERT;
            pick_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            rd_vld_reg   <= cmd.rd_en;
            rd_shift_reg <= cmd.rd_shift;
            rd_idx_reg   <= ptr_reg;
            out_vld_reg  <= out_vld_next;
            if (cmd.load_in)
            begin
                act_reg <= in_action;
            end
            if (take)
            begin
                pick_reg <= rd_idx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= in_rec;
        end
        if (take)
        begin
            best_reg <= rd_data_reg;
        end
        if (cmd.finish)
        begin
            out_ok_reg  <= can_insert || can_remove;
            out_rec_reg <= can_remove ? best_reg : '0;
            out_occ_reg <= mkrt_pkg::OCC_W'(count_next);
        end
    end

    assign out_valid = out_vld_reg;
    assign out_ok    = out_ok_reg;
    assign out_rec   = out_rec_reg;
    assign out_occ   = out_occ_reg;

endmodule

### test/record_table_sb_pkg.sv
// scoreboard for the min-key record table testbench: shadow copy of the table and owed results
// depends on mkrt_pkg for record layout, sizes and action codes
package record_table_sb_pkg;

    import mkrt_pkg::*;

    typedef struct {
        logic                done_ok;
        logic [KEY_W-1:0]    removed_key;
        logic [ID_W-1:0]     removed_id;
        logic [HANDLE_W-1:0] removed_name;
        logic [OCC_W-1:0]    occupancy;
    } table_outcome_t;

    class record_table_scoreboard;

        rec_t           shadow_records[DEPTH];
        int unsigned    shadow_count;
        table_outcome_t owed_outcomes[$];
        int unsigned    mismatches;

        function new();
            shadow_count = 0;
            mismatches   = 0;
        endfunction

        // work out what the table answers to an accepted item and queue it
        function void note_item(logic action, rec_t rec);
            table_outcome_t outcome;
            int unsigned    pick;
            int unsigned    i;
            outcome = '{default: '0};
            if (action == ACT_INSERT)
            begin
                if (shadow_count < DEPTH)
                begin
                    shadow_records[shadow_count] = rec;
                    shadow_count++;
                    outcome.done_ok = 1'b1;
                end
            end
            else if (shadow_count > 0)
            begin
                // oldest to newest, ties move to the newer record
                pick = 0;
                for (i = 1; i < shadow_count; i++)
                    if (shadow_records[i].key <= shadow_records[pick].key)
                        pick = i;
                outcome.done_ok      = 1'b1;
                outcome.removed_key  = shadow_records[pick].key;
                outcome.removed_id   = shadow_records[pick].id;
                outcome.removed_name = shadow_records[pick].handle;
                for (i = pick; i + 1 < shadow_count; i++)
                    shadow_records[i] = shadow_records[i + 1];
                shadow_count--;
            end
            outcome.occupancy = OCC_W'(shadow_count);
            owed_outcomes.push_back(outcome);
        endfunction

        function void flag_field(string field, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", field, want, got);
        endfunction

        function void check_result(table_outcome_t got);
            table_outcome_t want;
            if (owed_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result arrived with no item outstanding");
                return;
            end
            want = owed_outcomes.pop_front();
            if (got.done_ok !== want.done_ok)
                flag_field("done_ok", want.done_ok, got.done_ok);
            if (got.removed_key !== want.removed_key)
                flag_field("removed_key", want.removed_key, got.removed_key);
            if (got.removed_id !== want.removed_id)
                flag_field("removed_id", want.removed_id, got.removed_id);
            if (got.removed_name !== want.removed_name)
                flag_field("removed_name", want.removed_name, got.removed_name);
            if (got.occupancy !== want.occupancy)
                flag_field("occupancy", want.occupancy, got.occupancy);
        endfunction

        function int pending();
            return owed_outcomes.size();
        endfunction

        function int unsigned mismatch_count();
            return mismatches;
        endfunction

    endclass

endpackage

### test/testbench.sv
// top-level testbench for min_key_record_table_top: drives insert and remove items,
// throttles both stream sides and checks every result against the shadow table
// depends on mkrt_pkg and record_table_sb_pkg
module testbench;

    import mkrt_pkg::*;
    import record_table_sb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;    // record_id[23:0], record_key[39:24], name_handle[71:40]
    logic        s_axis_tuser;    // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;    // removed_key[15:0], removed_id[39:16], removed_name[71:40],
                                  // occupancy[77:72]
    logic        m_axis_tuser;    // done_ok

    record_table_scoreboard table_sb;

    // both sides stop idling while this is set
    bit          quiet;
    int unsigned results_seen;

    min_key_record_table_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // keys lean toward a tiny range so equal minimum keys show up often
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll < 4)
            return KEY_W'($urandom_range(7));
        else if (roll == 4)
            return '0;
        else if (roll == 5)
            return '1;
        else
            return KEY_W'($urandom);
    endfunction

    // offer one item, wait for the handshake, then tell the scoreboard
    task automatic offer_item(logic action, logic [ID_W-1:0] rid, logic [KEY_W-1:0] rkey,
                              logic [HANDLE_W-1:0] rname);
        rec_t rec;
        int   gap;
        if (!quiet && $urandom_range(99) < 9)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= {rname, rkey, rid};
        do @(posedge clk); while (!s_axis_tready);
        rec.key    = rkey;
        rec.id     = rid;
        rec.handle = rname;
        table_sb.note_item(action, rec);
    endtask

    // remove items carry random junk in the fields the block ignores
    task automatic offer_remove();
        offer_item(ACT_REMOVE, ID_W'($urandom), KEY_W'($urandom), $urandom);
    endtask

    task automatic run_directed();
        // remove from an empty table
        offer_remove();
        // field extremes, then a three-way tie on one key
        offer_item(ACT_INSERT, 24'hFFFFFF, 16'hFFFF, 32'hFFFFFFFF);
        offer_item(ACT_INSERT, 24'h000000, 16'h0000, 32'h00000000);
        offer_item(ACT_INSERT, 24'h000001, 16'h0005, 32'h00000011);
        offer_item(ACT_INSERT, 24'h000002, 16'h0005, 32'h00000022);
        offer_item(ACT_INSERT, 24'h000003, 16'h0005, 32'h00000033);
        // zero key first, then the tied records newest first
        offer_remove();
        offer_remove();
        offer_remove();
        // alternating bit patterns on a tied zero key
        offer_item(ACT_INSERT, 24'hAAAAAA, 16'h0000, 32'h55555555);
        offer_item(ACT_INSERT, 24'h555555, 16'h0000, 32'hAAAAAAAA);
        // drain completely and go one past empty
        repeat (5) offer_remove();
    endtask

    // random phases: filling, draining and mixed, so full and empty are both hit often
    task automatic run_random(int unsigned count);
        int unsigned sent;
        int unsigned phase_len;
        int unsigned insert_pct;
        sent = 0;
        while (sent < count)
        begin
            phase_len  = $urandom_range(20, 60);
            case ($urandom_range(2))
                0: insert_pct = 85;
                1: insert_pct = 15;
                default: insert_pct = 50;
            endcase
            repeat (phase_len)
            begin
                // a long stretch with no idling on either side
                quiet = (sent >= 150 && sent < 260);
                if ($urandom_range(99) < insert_pct)
                    offer_item(ACT_INSERT, ID_W'($urandom), pick_key(), $urandom);
                else
                    offer_remove();
                sent++;
            end
        end
        quiet = 1'b0;
    endtask

    // result side: random stalls, one long hold-off, and the check of each result
    initial
    begin : result_sink
        table_outcome_t got;
        bit             held_off;
        held_off      = 1'b0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.done_ok      = m_axis_tuser;
                got.removed_key  = m_axis_tdata[15:0];
                got.removed_id   = m_axis_tdata[39:16];
                got.removed_name = m_axis_tdata[71:40];
                got.occupancy    = m_axis_tdata[77:72];
                table_sb.check_result(got);
                results_seen++;
            end
            if (!held_off && results_seen == 100)
            begin
                // let the block back up while the sender keeps offering
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= (quiet || $urandom_range(99) >= 9);
        end
    end

    // stimulus and end of run
    initial
    begin
        table_sb      = new();
        quiet         = 1'b0;
        results_seen  = 0;
        rst_n         = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= ACT_INSERT;
        s_axis_tdata  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(400);
        s_axis_tvalid <= 1'b0;

        // drain, then leave room for a worst-case remove to show up late
        while (table_sb.pending() != 0) @(posedge clk);
        repeat (100) @(posedge clk);

        if (table_sb.mismatch_count() == 0 && table_sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule
